@@ hdl/i2cm_seq_pkg.sv @@
package i2cm_seq_pkg;

  // Software operations carried by each input beat
  typedef enum logic [1:0] {
    OP_PUSH     = 2'd0,
    OP_START_WR = 2'd1,
    OP_START_RD = 2'd2,
    OP_EVENT    = 2'd3
  } op_t;

  // Bus-core event codes; codes 5 to 7 carry no meaning
  localparam logic [2:0] EV_START_SENT = 3'd0;
  localparam logic [2:0] EV_ADDR_ACK   = 3'd1;
  localparam logic [2:0] EV_TX_READY   = 3'd2;
  localparam logic [2:0] EV_RX_BYTE    = 3'd3;
  localparam logic [2:0] EV_ACK_FAIL   = 3'd4;

  localparam logic [3:0] RETRY_LIMIT_RESET = 4'd3;
  localparam logic [3:0] FAIL_COUNT_MAX    = 4'd15;
  localparam logic [7:0] ZERO_BYTE         = 8'h00;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic [7:0] target_address;
    logic       send_zero_only;
    logic [5:0] read_count;
    logic [2:0] bus_event;
  } in_item_t;

  typedef struct packed {
    logic       drive_valid;
    logic [7:0] drive_byte;
    logic       request_start;
    logic       request_stop;
    logic       ack_enable;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic [4:0] rx_position;
    logic       transfer_done;
    logic       transfer_failed;
    logic       busy_res;
  } out_item_t;

endpackage

@@ hdl/i2c_master_transfer_sequencer.sv @@
// I2C master transfer sequencer.
// Input channel (in_valid / in_stall / in_data): one beat per software
// operation or bus-core event. Software pushes transmit bytes, then starts a
// write or a read; the bus core reports start sent, address ack, transmitter
// ready, byte received and ack failure.
// Result channel (out_valid / out_stall / out_data): exactly one beat per
// input beat, in order, carrying the byte to drive, start/stop requests, the
// ACK setting, a received byte with its position and the done/failed/busy
// flags.
// Config channel (cfg_valid / cfg_ready / cfg_data): writes retry_limit;
// cfg_ready is always high. Write it only while the block is idle.
// Path: an accepted input beat passes the read stage (the synchronous
// transmit-byte memory read) and then the output register. Throughput: one
// beat per cycle while in_stall is low, set by the single read port of
// the transmit memory and the scalar state updated in the accept cycle.
// A two-entry output buffer keeps accepting while a result waits; in_stall
// rises only while out_stall holds the head beat and a second result is held.
// Reset (rst_n low, synchronous) clears all control state and sets
// retry_limit to 3; the transmit memory is not cleared.
module i2c_master_transfer_sequencer #(
  parameter int MAX_BYTES = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  i2cm_seq_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output i2cm_seq_pkg::out_item_t  out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [3:0]               cfg_data
);

  localparam int CNT_W = $clog2(MAX_BYTES + 1);
  localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CW    = (CNT_W > 6) ? CNT_W : 6;

  // Transmit byte memory: one write port, one registered read port
  logic [7:0]       tx_mem [MAX_BYTES];
  logic [7:0]       mem_q_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [7:0]       mem_wd;
  logic [IDX_W-1:0] mem_ra;

  // Scalar transfer state
  logic [CNT_W-1:0] tx_fill_r, tx_fill_nxt;
  logic [CNT_W-1:0] byte_position_r, byte_position_nxt;
  logic [CNT_W-1:0] read_total_r, read_total_nxt;
  logic [7:0]       peer_address_r, peer_address_nxt;
  logic             write_active_r, write_active_nxt;
  logic             read_active_r, read_active_nxt;
  logic [3:0]       failure_count_r, failure_count_nxt;
  logic             ack_on_r, ack_on_nxt;
  logic [3:0]       retry_limit_r;

  // Read stage: result waiting for the memory data
  logic                    a_valid_r;
  logic                    a_rd_r, a_rd_nxt;
  i2cm_seq_pkg::out_item_t a_item_r, a_item_nxt;

  // Two-entry output buffer
  logic                    head_valid_r, head_valid_nxt;
  logic                    skid_valid_r, skid_valid_nxt;
  i2cm_seq_pkg::out_item_t head_r, head_nxt;
  i2cm_seq_pkg::out_item_t skid_r, skid_nxt;
  i2cm_seq_pkg::out_item_t push_item;

  logic             in_accept;
  logic             pop;
  logic [1:0]       occ;
  logic [CNT_W-1:0] pos_inc;
  logic [CW-1:0]    pos_ext;
  logic [CW-1:0]    count_ext;
  logic [3:0]       fail_inc;

  function automatic logic [CNT_W-1:0] pos_inc_fill(input logic [CNT_W-1:0] v);
    pos_inc_fill = v + CNT_W'(1);
  endfunction

  // Room check: the read stage always drains into the buffer next cycle
  assign pop       = head_valid_r & ~out_stall;
  assign occ       = {1'b0, head_valid_r} + {1'b0, skid_valid_r} + {1'b0, a_valid_r};
  assign in_stall  = (occ - {1'b0, pop}) > 2'd1;
  assign in_accept = in_valid & ~in_stall;

  assign out_valid = head_valid_r;
  assign out_data  = head_r;
  assign cfg_ready = 1'b1;

  assign mem_ra    = byte_position_r[IDX_W-1:0];
  assign pos_inc   = byte_position_r + CNT_W'(1);
  assign pos_ext   = CW'(byte_position_r);
  assign fail_inc  = (failure_count_r != i2cm_seq_pkg::FAIL_COUNT_MAX) ?
                     failure_count_r + 4'd1 : failure_count_r;

  always_comb begin
    tx_fill_nxt       = tx_fill_r;
    byte_position_nxt = byte_position_r;
    read_total_nxt    = read_total_r;
    peer_address_nxt  = peer_address_r;
    write_active_nxt  = write_active_r;
    read_active_nxt   = read_active_r;
    failure_count_nxt = failure_count_r;
    ack_on_nxt        = ack_on_r;
    a_item_nxt        = '0;
    a_rd_nxt          = 1'b0;
    mem_we            = 1'b0;
    mem_wa            = tx_fill_r[IDX_W-1:0];
    mem_wd            = in_data.data_byte;
    count_ext         = CW'(in_data.read_count);

    if (in_accept) begin
      unique case (i2cm_seq_pkg::op_t'(in_data.operation))
        i2cm_seq_pkg::OP_PUSH: begin
          // Drop the push when the queue is full
          if (tx_fill_r < CNT_W'(MAX_BYTES)) begin
            mem_we      = 1'b1;
            tx_fill_nxt = pos_inc_fill(tx_fill_r);
          end
        end
        i2cm_seq_pkg::OP_START_WR: begin
          if (in_data.send_zero_only) begin
            mem_we      = 1'b1;
            mem_wa      = '0;
            mem_wd      = i2cm_seq_pkg::ZERO_BYTE;
            tx_fill_nxt = CNT_W'(1);
          end
          peer_address_nxt         = in_data.target_address;
          write_active_nxt         = 1'b1;
          read_active_nxt          = 1'b0;
          byte_position_nxt        = '0;
          failure_count_nxt        = '0;
          a_item_nxt.request_start = 1'b1;
        end
        i2cm_seq_pkg::OP_START_RD: begin
          // Clamp the count into 1 .. MAX_BYTES
          if (count_ext == '0) begin
            count_ext = CW'(1);
          end
          if (count_ext > CW'(MAX_BYTES)) begin
            count_ext = CW'(MAX_BYTES);
          end
          read_total_nxt           = count_ext[CNT_W-1:0];
          peer_address_nxt         = in_data.target_address;
          read_active_nxt          = 1'b1;
          write_active_nxt         = 1'b0;
          byte_position_nxt        = '0;
          failure_count_nxt        = '0;
          a_item_nxt.request_start = 1'b1;
        end
        i2cm_seq_pkg::OP_EVENT: begin
          if (write_active_r || read_active_r) begin
            unique case (in_data.bus_event)
              i2cm_seq_pkg::EV_START_SENT: begin
                a_item_nxt.drive_valid = 1'b1;
                a_item_nxt.drive_byte  = peer_address_r;
              end
              i2cm_seq_pkg::EV_ADDR_ACK: begin
                if (read_active_r) begin
                  // A single-byte read NACKs its only byte and stops
                  if (read_total_r == CNT_W'(1)) begin
                    ack_on_nxt              = 1'b0;
                    a_item_nxt.request_stop = 1'b1;
                  end else begin
                    ack_on_nxt = 1'b1;
                  end
                end
              end
              i2cm_seq_pkg::EV_TX_READY: begin
                if (write_active_r) begin
                  if (byte_position_r < tx_fill_r) begin
                    a_item_nxt.drive_valid = 1'b1;
                    a_rd_nxt               = 1'b1;
                    byte_position_nxt      = pos_inc;
                  end
                  if (byte_position_nxt >= tx_fill_r) begin
                    a_item_nxt.request_stop  = 1'b1;
                    a_item_nxt.transfer_done = 1'b1;
                    write_active_nxt         = 1'b0;
                    read_active_nxt          = 1'b0;
                    tx_fill_nxt              = '0;
                    byte_position_nxt        = '0;
                    read_total_nxt           = '0;
                  end
                end
              end
              i2cm_seq_pkg::EV_RX_BYTE: begin
                if (read_active_r) begin
                  a_item_nxt.rx_valid    = 1'b1;
                  a_item_nxt.rx_data     = in_data.data_byte;
                  a_item_nxt.rx_position = pos_ext[4:0];
                  byte_position_nxt      = pos_inc;
                  // NACK the byte that will be last
                  if ({1'b0, pos_inc} + (CNT_W+1)'(1) == {1'b0, read_total_r}) begin
                    ack_on_nxt = 1'b0;
                  end
                  if (pos_inc >= read_total_r) begin
                    a_item_nxt.request_stop  = 1'b1;
                    a_item_nxt.transfer_done = 1'b1;
                    write_active_nxt         = 1'b0;
                    read_active_nxt          = 1'b0;
                    tx_fill_nxt              = '0;
                    byte_position_nxt        = '0;
                    read_total_nxt           = '0;
                  end
                end
              end
              i2cm_seq_pkg::EV_ACK_FAIL: begin
                failure_count_nxt = fail_inc;
                if (byte_position_r == '0) begin
                  a_item_nxt.request_stop = 1'b1;
                end
                if (fail_inc >= retry_limit_r) begin
                  a_item_nxt.transfer_failed = 1'b1;
                  write_active_nxt           = 1'b0;
                  read_active_nxt            = 1'b0;
                  tx_fill_nxt                = '0;
                  byte_position_nxt          = '0;
                  read_total_nxt             = '0;
                end else if (byte_position_r == '0) begin
                  a_item_nxt.request_start = 1'b1;
                end else begin
                  // Step back to resend the byte that failed
                  byte_position_nxt = byte_position_r - CNT_W'(1);
                end
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end

    a_item_nxt.ack_enable = ack_on_nxt;
    a_item_nxt.busy_res   = write_active_nxt | read_active_nxt;
  end

  // Resolve the transmit byte from the memory read issued in the accept cycle
  always_comb begin
    push_item = a_item_r;
    if (a_rd_r) begin
      push_item.drive_byte = mem_q_r;
    end
  end

  always_comb begin
    head_nxt       = head_r;
    skid_nxt       = skid_r;
    head_valid_nxt = head_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (pop) begin
      if (skid_valid_r) begin
        head_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        head_valid_nxt = 1'b0;
      end
    end
    if (a_valid_r) begin
      if (!head_valid_nxt) begin
        head_nxt       = push_item;
        head_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_item;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tx_mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= tx_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_fill_r       <= '0;
      byte_position_r <= '0;
      read_total_r    <= '0;
      peer_address_r  <= '0;
      write_active_r  <= 1'b0;
      read_active_r   <= 1'b0;
      failure_count_r <= '0;
      ack_on_r        <= 1'b0;
      retry_limit_r   <= i2cm_seq_pkg::RETRY_LIMIT_RESET;
      a_valid_r       <= 1'b0;
      head_valid_r    <= 1'b0;
      skid_valid_r    <= 1'b0;
    end else begin
      tx_fill_r       <= tx_fill_nxt;
      byte_position_r <= byte_position_nxt;
      read_total_r    <= read_total_nxt;
      peer_address_r  <= peer_address_nxt;
      write_active_r  <= write_active_nxt;
      read_active_r   <= read_active_nxt;
      failure_count_r <= failure_count_nxt;
      ack_on_r        <= ack_on_nxt;
      a_valid_r       <= in_accept;
      head_valid_r    <= head_valid_nxt;
      skid_valid_r    <= skid_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        retry_limit_r <= cfg_data;
      end
    end
  end

  // Payload registers hold without reset
  always_ff @(posedge clk) begin
    a_item_r <= a_item_nxt;
    a_rd_r   <= a_rd_nxt;
    head_r   <= head_nxt;
    skid_r   <= skid_nxt;
  end

`ifndef ASSERT_OFF
  a_skid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> head_valid_r)
    else $error("skid entry held without a head entry");

  a_read_stage_room: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r |-> !skid_valid_r)
    else $error("read stage valid while output buffer is full");

  a_done_xor_failed: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid_r |-> !(head_r.transfer_done && head_r.transfer_failed))
    else $error("transfer reported done and failed at once");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tx_fill_r <= CNT_W'(MAX_BYTES))
    else $error("transmit fill beyond capacity");

  a_end_clears_busy: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && (a_item_r.transfer_done || a_item_r.transfer_failed) |-> !a_item_r.busy_res)
    else $error("transfer ended but still busy");
`endif

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam int TX_DEPTH   = 32;
  localparam int CYCLE_CAP  = 200000;
  localparam int LONG_HOLD  = 100;
  // Event codes the bus core never sends; the block must ignore them
  localparam logic [2:0] EV_RESERVED_LO = 3'd5;
  localparam logic [2:0] EV_RESERVED_MID = 3'd6;
  localparam logic [2:0] EV_RESERVED_HI = 3'd7;

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  i2cm_seq_pkg::in_item_t  in_data = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  i2cm_seq_pkg::out_item_t out_data;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [3:0]              cfg_data = '0;

  i2c_master_transfer_sequencer #(
    .MAX_BYTES(TX_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Sequencer state as predicted from the beats the block has taken
  // ---------------------------------------------------------------------------
  logic [7:0] tx_bytes [TX_DEPTH];
  logic [5:0] tx_fill     = '0;
  logic [5:0] position    = '0;
  logic [5:0] read_len    = '0;
  logic [7:0] peer_addr   = '0;
  logic       writing     = 1'b0;
  logic       reading     = 1'b0;
  logic [3:0] fail_cnt    = '0;
  logic       ack_en      = 1'b0;
  logic [3:0] retry_limit = i2cm_seq_pkg::RETRY_LIMIT_RESET;

  i2cm_seq_pkg::in_item_t  pending_beats [$];
  i2cm_seq_pkg::out_item_t expected_results [$];

  int queued_total   = 0;
  int accepted_total = 0;
  int result_total   = 0;
  int done_count     = 0;
  int abort_count    = 0;
  int rx_count       = 0;
  int limit_writes   = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;
  int hold_requests  = 0;

  // Finish the current transfer, done or aborted; failure_count survives
  function automatic void drop_transfer();
    writing  = 1'b0;
    reading  = 1'b0;
    tx_fill  = '0;
    position = '0;
    read_len = '0;
  endfunction

  // Advance the predicted state by one beat and return the result it causes
  function automatic i2cm_seq_pkg::out_item_t sequencer_step(i2cm_seq_pkg::in_item_t b);
    i2cm_seq_pkg::out_item_t r;
    int                      rd_len;
    r = '0;
    case (i2cm_seq_pkg::op_t'(b.operation))
      i2cm_seq_pkg::OP_PUSH: begin
        // Full queue: drop the byte
        if (tx_fill < TX_DEPTH) begin
          tx_bytes[tx_fill[4:0]] = b.data_byte;
          tx_fill = tx_fill + 6'd1;
        end
      end
      i2cm_seq_pkg::OP_START_WR: begin
        if (b.send_zero_only) begin
          tx_bytes[0] = i2cm_seq_pkg::ZERO_BYTE;
          tx_fill = 6'd1;
        end
        peer_addr = b.target_address;
        writing = 1'b1;
        reading = 1'b0;
        position = '0;
        fail_cnt = '0;
        r.request_start = 1'b1;
      end
      i2cm_seq_pkg::OP_START_RD: begin
        // Zero reads one byte, anything past the buffer saturates
        rd_len = int'(b.read_count);
        if (rd_len == 0) rd_len = 1;
        if (rd_len > TX_DEPTH) rd_len = TX_DEPTH;
        read_len = 6'(rd_len);
        peer_addr = b.target_address;
        reading = 1'b1;
        writing = 1'b0;
        position = '0;
        fail_cnt = '0;
        r.request_start = 1'b1;
      end
      i2cm_seq_pkg::OP_EVENT: begin
        if (writing || reading) begin
          case (b.bus_event)
            i2cm_seq_pkg::EV_START_SENT: begin
              r.drive_valid = 1'b1;
              r.drive_byte = peer_addr;
            end
            i2cm_seq_pkg::EV_ADDR_ACK: begin
              if (reading) begin
                // Single-byte read: NACK the only byte and stop after it
                if (read_len == 1) begin
                  ack_en = 1'b0;
                  r.request_stop = 1'b1;
                end else begin
                  ack_en = 1'b1;
                end
              end
            end
            i2cm_seq_pkg::EV_TX_READY: begin
              if (writing) begin
                if (position < tx_fill) begin
                  r.drive_valid = 1'b1;
                  r.drive_byte = tx_bytes[position[4:0]];
                  position = position + 6'd1;
                end
                if (position >= tx_fill) begin
                  r.request_stop = 1'b1;
                  r.transfer_done = 1'b1;
                  done_count++;
                  drop_transfer();
                end
              end
            end
            i2cm_seq_pkg::EV_RX_BYTE: begin
              if (reading) begin
                r.rx_valid = 1'b1;
                r.rx_data = b.data_byte;
                r.rx_position = position[4:0];
                rx_count++;
                position = position + 6'd1;
                if (position + 1 == read_len) ack_en = 1'b0;
                if (position >= read_len) begin
                  r.request_stop = 1'b1;
                  r.transfer_done = 1'b1;
                  done_count++;
                  drop_transfer();
                end
              end
            end
            i2cm_seq_pkg::EV_ACK_FAIL: begin
              if (fail_cnt < i2cm_seq_pkg::FAIL_COUNT_MAX) fail_cnt = fail_cnt + 4'd1;
              if (position == 0) r.request_stop = 1'b1;
              if (fail_cnt >= retry_limit) begin
                r.transfer_failed = 1'b1;
                abort_count++;
                drop_transfer();
              end else if (position == 0) begin
                r.request_start = 1'b1;
              end else begin
                position = position - 6'd1;
              end
            end
            default: ;
          endcase
        end
      end
    endcase
    r.ack_enable = ack_en;
    r.busy_res = writing | reading;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s = %h, expected %h", result_total, name,
                                got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic i2cm_seq_pkg::in_item_t mk_beat(i2cm_seq_pkg::op_t op,
                                                     logic [7:0] data, logic [7:0] addr,
                                                     logic zero, logic [5:0] cnt,
                                                     logic [2:0] ev);
    i2cm_seq_pkg::in_item_t b;
    b.operation      = op;
    b.data_byte      = data;
    b.target_address = addr;
    b.send_zero_only = zero;
    b.read_count     = cnt;
    b.bus_event      = ev;
    return b;
  endfunction

  task automatic offer(i2cm_seq_pkg::in_item_t b);
    pending_beats.push_back(b);
    queued_total++;
  endtask

  // Fields an event does not use carry random values to toggle every bit
  task automatic offer_event(logic [2:0] ev);
    offer(mk_beat(i2cm_seq_pkg::OP_EVENT, 8'($urandom), 8'($urandom), 1'($urandom),
                  6'($urandom), ev));
  endtask

  // Event with all unused fields zero, for the directed part
  task automatic offer_bare_event(logic [2:0] ev);
    offer(mk_beat(i2cm_seq_pkg::OP_EVENT, 8'h00, 8'h00, 1'b0, 6'd0, ev));
  endtask

  task automatic address_phase();
    offer_event(i2cm_seq_pkg::EV_START_SENT);
    offer_event(i2cm_seq_pkg::EV_ADDR_ACK);
  endtask

  // Well-formed write: queue bytes, start, then ready events with
  // occasional acknowledge failures, retries and stray events mixed in
  task automatic gen_write();
    int  n;
    int  steps;
    int  pick;
    logic zero;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 34) : $urandom_range(0, 6);
    zero = ($urandom_range(0, 9) == 0);
    repeat (n) offer(mk_beat(i2cm_seq_pkg::OP_PUSH, 8'($urandom), 8'($urandom),
                             1'($urandom), 6'($urandom), 3'($urandom)));
    offer(mk_beat(i2cm_seq_pkg::OP_START_WR, 8'($urandom), 8'($urandom), zero,
                  6'($urandom), 3'($urandom)));
    address_phase();
    steps = zero ? 1 : ((n == 0) ? 1 : n);
    steps = steps + $urandom_range(0, 1);
    for (int i = 0; i < steps; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        offer_event(i2cm_seq_pkg::EV_ACK_FAIL);
        if ($urandom_range(0, 1)) address_phase();
        offer_event(i2cm_seq_pkg::EV_TX_READY);
      end else if (pick < 13) begin
        offer_event(3'($urandom_range(0, 7)));
      end else begin
        offer_event(i2cm_seq_pkg::EV_TX_READY);
      end
    end
  endtask

  // Well-formed read: mostly short counts, sometimes zero, full or oversized
  task automatic gen_read();
    int cnt;
    int eff;
    case ($urandom_range(0, 9))
      0: cnt = 0;
      1: cnt = TX_DEPTH;
      2: cnt = $urandom_range(33, 63);
      3: cnt = $urandom_range(7, 31);
      default: cnt = $urandom_range(1, 6);
    endcase
    eff = (cnt == 0) ? 1 : ((cnt > TX_DEPTH) ? TX_DEPTH : cnt);
    offer(mk_beat(i2cm_seq_pkg::OP_START_RD, 8'($urandom), 8'($urandom), 1'($urandom),
                  6'(cnt), 3'($urandom)));
    address_phase();
    for (int i = 0; i < eff; i++) begin
      if ($urandom_range(0, 99) < 8) begin
        offer_event(i2cm_seq_pkg::EV_ACK_FAIL);
        if ($urandom_range(0, 1)) address_phase();
      end
      offer_event(i2cm_seq_pkg::EV_RX_BYTE);
    end
  endtask

  // Wait on the falling edge until every beat is taken and every result seen
  task automatic settle();
    while (accepted_total != queued_total || expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write retry_limit over the config channel while the block is idle
  task automatic write_retry_limit(logic [3:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    retry_limit = value;
    limit_writes++;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer pending beats in bursts of random length with random gaps;
  // hold a beat steady until the block takes it, and predict on each take
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(sequencer_step(in_data));
        accepted_total++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_beats.pop_front();
          if (burst_left <= 1) begin
            // Pick the next burst; a quarter of them run back to back
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: a new pattern per window (none, light, heavy, periodic),
  // plus a long hold-off whenever the stimulus asks for one
  // ---------------------------------------------------------------------------
  int hold_left   = 0;
  int hold_served = 0;
  int window_left = 0;
  int stall_mode  = 0;
  int stall_tick  = 0;

  always @(posedge clk) begin
    stall_tick++;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      if (window_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        window_left = $urandom_range(8, 80);
      end else begin
        window_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 30);
        2: out_stall <= ($urandom_range(0, 99) < 75);
        default: out_stall <= (stall_tick % 3 == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each taken result with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    i2cm_seq_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result arrived with no beat outstanding");
      end else begin
        want = expected_results.pop_front();
        check_field("drive_valid", 8'(out_data.drive_valid), 8'(want.drive_valid));
        check_field("drive_byte", out_data.drive_byte, want.drive_byte);
        check_field("request_start", 8'(out_data.request_start), 8'(want.request_start));
        check_field("request_stop", 8'(out_data.request_stop), 8'(want.request_stop));
        check_field("ack_enable", 8'(out_data.ack_enable), 8'(want.ack_enable));
        check_field("rx_valid", 8'(out_data.rx_valid), 8'(want.rx_valid));
        check_field("rx_data", out_data.rx_data, want.rx_data);
        check_field("rx_position", 8'(out_data.rx_position), 8'(want.rx_position));
        check_field("transfer_done", 8'(out_data.transfer_done), 8'(want.transfer_done));
        check_field("transfer_failed", 8'(out_data.transfer_failed),
                    8'(want.transfer_failed));
        check_field("busy_res", 8'(out_data.busy_res), 8'(want.busy_res));
      end
      result_total++;
    end
  end

  // Watchdog: drop the run if it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("tb: timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed beats under the reset retry limit, then random phases,
  // each under its own retry limit written while the block is idle
  // ---------------------------------------------------------------------------
  initial begin
    int          target;
    logic [3:0]  limits [6];
    logic [31:0] raw;
    limits = '{4'd15, 4'd1, 4'd0, 4'($urandom_range(2, 14)), 4'd7, 4'd15};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Idle events and a reserved code do nothing
    offer_bare_event(i2cm_seq_pkg::EV_START_SENT);
    offer_bare_event(EV_RESERVED_HI);
    // Two-byte write with a data failure and resend
    offer(mk_beat(i2cm_seq_pkg::OP_PUSH, 8'hFF, 8'h00, 1'b0, 6'd0,
                  i2cm_seq_pkg::EV_START_SENT));
    offer(mk_beat(i2cm_seq_pkg::OP_PUSH, 8'h00, 8'h00, 1'b0, 6'd0,
                  i2cm_seq_pkg::EV_START_SENT));
    offer(mk_beat(i2cm_seq_pkg::OP_START_WR, 8'h00, 8'hA4, 1'b0, 6'd0,
                  i2cm_seq_pkg::EV_START_SENT));
    offer_bare_event(i2cm_seq_pkg::EV_START_SENT);
    offer_bare_event(i2cm_seq_pkg::EV_ADDR_ACK);
    offer_bare_event(i2cm_seq_pkg::EV_TX_READY);
    offer_bare_event(i2cm_seq_pkg::EV_ACK_FAIL);
    offer_bare_event(i2cm_seq_pkg::EV_TX_READY);
    offer_bare_event(i2cm_seq_pkg::EV_TX_READY);
    // Zero-byte-only write, with a reserved code inside the transfer
    offer(mk_beat(i2cm_seq_pkg::OP_START_WR, 8'hFF, 8'h00, 1'b1, 6'd63, EV_RESERVED_HI));
    offer_bare_event(EV_RESERVED_LO);
    offer_bare_event(i2cm_seq_pkg::EV_TX_READY);
    // Read count zero becomes a single-byte read: NACK and stop on address ack
    offer(mk_beat(i2cm_seq_pkg::OP_START_RD, 8'h00, 8'hFF, 1'b0, 6'd0,
                  i2cm_seq_pkg::EV_START_SENT));
    offer_bare_event(i2cm_seq_pkg::EV_ADDR_ACK);
    offer(mk_beat(i2cm_seq_pkg::OP_EVENT, 8'hFF, 8'h00, 1'b0, 6'd0,
                  i2cm_seq_pkg::EV_RX_BYTE));
    // Oversized read, abandoned by a zero-only write that fails out
    offer(mk_beat(i2cm_seq_pkg::OP_START_RD, 8'h00, 8'h01, 1'b0, 6'd63,
                  i2cm_seq_pkg::EV_START_SENT));
    offer(mk_beat(i2cm_seq_pkg::OP_START_WR, 8'h00, 8'h5A, 1'b1, 6'd0,
                  i2cm_seq_pkg::EV_START_SENT));
    offer_bare_event(i2cm_seq_pkg::EV_ACK_FAIL);
    offer_bare_event(i2cm_seq_pkg::EV_ACK_FAIL);
    offer_bare_event(i2cm_seq_pkg::EV_ACK_FAIL);
    offer_bare_event(EV_RESERVED_MID);
    // Empty write: the first ready event finishes it
    offer(mk_beat(i2cm_seq_pkg::OP_START_WR, 8'h00, 8'h42, 1'b0, 6'd0,
                  i2cm_seq_pkg::EV_START_SENT));
    offer_bare_event(i2cm_seq_pkg::EV_TX_READY);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      write_retry_limit(limits[ph]);
      // Hold the receiver off early in one phase so the block backs up
      if (ph == 1) hold_requests++;
      target = queued_total + 65;
      while (queued_total < target) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8: gen_write();
          9, 10, 11, 12, 13, 14, 15, 16: gen_read();
          default: begin
            repeat ($urandom_range(1, 3)) begin
              raw = $urandom;
              offer(raw[$bits(i2cm_seq_pkg::in_item_t)-1:0]);
            end
          end
        endcase
      end
      // Pause the sender until every result of the phase is in
      settle();
    end

    repeat (8) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    $display("tb: %0d beats checked over %0d retry-limit writes plus the reset value",
             result_total, limit_writes);
    $display("tb: %0d transfers completed, %0d aborted, %0d bytes received, %0d mismatches",
             done_count, abort_count, rx_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
